@@ hw/rtl/cop_pkg.sv @@
// Package with shared types and constants of the causal onset peak picker.
package cop_pkg;
  localparam int WindowDepth = 64;
  localparam int PtrBits = $clog2(WindowDepth);
  localparam int FluxBits = 24;
  localparam int TimeBits = 32;
  localparam int FrameBits = 32;
  localparam int CfgBits = 32;
  localparam int IdxBits = 3;
  localparam int FillBits = PtrBits + 1;
  localparam int SumBits = FluxBits + FillBits;
  localparam int SqBits = 2 * FluxBits + FillBits;
  localparam int VarBits = 2 * SumBits;
  localparam int RootBits = SumBits;
  localparam int NumBits = SumBits + 14;
  localparam int DenBits = FillBits + 8;
  localparam int ThrBits = 32;

  localparam logic [IdxBits-1:0] CfgHistory = 3'd0;
  localparam logic [IdxBits-1:0] CfgGain = 3'd1;
  localparam logic [IdxBits-1:0] CfgOffset = 3'd2;
  localparam logic [IdxBits-1:0] CfgFloor = 3'd3;
  localparam logic [IdxBits-1:0] CfgRefract = 3'd4;

  localparam logic [2:0] StNone = 3'd0;
  localparam logic [2:0] StOnset = 3'd1;
  localparam logic [2:0] StUnordered = 3'd2;
  localparam logic [2:0] StGap = 3'd3;
  localparam logic [2:0] StCenter = 3'd4;
  localparam logic [2:0] StReady = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_RDOLD, S_VAR, S_SQRT, S_MUL, S_DIV, S_DECIDE, S_OUT
  } fsm_t;

  typedef struct packed {
    logic start;
    logic [VarBits-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic done;
    logic [RootBits-1:0] root;
  } sqrt_rsp_t;
endpackage

@@ hw/rtl/cop_if.sv @@
// Valid-ready stream interface carrying one payload per beat.
interface cop_if #(parameter int W = 8) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/causal_onset_peak_picker.sv @@
// Top level of the causal onset peak picker.
// One input beat yields exactly one result beat, and a new frame is accepted
// only after the result of the previous one has been taken, in the cycle after
// that result beat at the earliest. A valid frame with a non-empty window passes
// through window memory reads and setup, a square root (one result bit per
// cycle for 31 bits), the numerator, a restoring divide (one quotient bit per
// cycle) and a decision before its result is offered. With an empty window the
// square root and divide are skipped, and an invalid frame has its result in
// the cycle after it is accepted. Writing history_length clears the window by
// resetting its fill count, so there is no clearing pass.
module causal_onset_peak_picker (
  input  logic clk,
  input  logic rst_n,
  cop_if.sink in_if,
  cop_if.source out_if,
  input  logic cfg_we,
  input  logic [cop_pkg::IdxBits-1:0] cfg_index,
  input  logic [cop_pkg::CfgBits-1:0] cfg_data
);
  import cop_pkg::*;

  logic [6:0] hist_r;
  logic [11:0] gain_r;
  logic [FluxBits-1:0] offs_r, floor_r;
  logic [TimeBits-1:0] refr_r;

  fsm_t st_r, st_nxt;
  logic [FrameBits-1:0] frm_r, lfrm_r, pfrm_r;
  logic [TimeBits-1:0] cen_r, rdy_r, lcen_r, lrdy_r, pcen_r, lon_r;
  logic [FluxBits-1:0] flx_r, pflx_r, prev_r;
  logic [ThrBits-1:0] pthr_r;
  logic pval_r, emv_r, seen_r;
  logic [PtrBits-1:0] ptr_r;
  logic [FillBits-1:0] fill_r;
  logic [SumBits-1:0] sum_r;
  logic [SqBits-1:0] sq_r;
  logic [VarBits-1:0] var_r;
  logic [NumBits-1:0] num_r, rem_r;
  logic [NumBits-1:0] quo_r;
  logic [5:0] cnt_r;
  logic [2:0] ost_r;
  logic [FrameBits-1:0] ofrm_r;
  logic [TimeBits-1:0] otime_r, oemit_r, odel_r;
  logic [FluxBits-1:0] oflx_r;
  logic [ThrBits-1:0] othr_r;

  logic [FrameBits-1:0] in_frame;
  logic [TimeBits-1:0] in_start, in_center, in_ready;
  logic [FluxBits-1:0] in_flux;
  assign {in_frame, in_start, in_center, in_ready, in_flux} = in_if.data;
  assign in_if.ready = (st_r == S_IDLE);
  assign out_if.valid = (st_r == S_OUT);
  assign out_if.data = {ost_r, ofrm_r, otime_r, oemit_r, odel_r, oflx_r, othr_r};

  logic [FillBits-1:0] len;
  always_comb begin
    if (hist_r == 7'd0) len = FillBits'(1);
    else if (hist_r > 7'(WindowDepth)) len = FillBits'(WindowDepth);
    else len = FillBits'(hist_r);
  end

  logic mem_we;
  logic [PtrBits-1:0] mem_addr;
  logic [FluxBits-1:0] mem_rd;
  cop_ram #(.WIDTH(FluxBits), .DEPTH(WindowDepth)) u_win (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(flx_r), .rdata(mem_rd)
  );

  sqrt_req_t sreq;
  sqrt_rsp_t srsp;
  cop_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

  logic [2:0] chk;
  always_comb begin
    if (in_start > in_center || in_center > in_ready) chk = StUnordered;
    else if (seen_r && in_frame != lfrm_r + 1'b1) chk = StGap;
    else if (seen_r && in_center <= lcen_r) chk = StCenter;
    else if (seen_r && in_ready <= lrdy_r) chk = StReady;
    else chk = StNone;
  end

  logic [DenBits-1:0] den;
  logic [NumBits:0] dtrial;
  logic [ThrBits:0] thr_sum;
  logic [ThrBits-1:0] thr;
  logic evict;
  assign den = {fill_r, 8'd0};
  assign evict = fill_r >= len;
  assign thr_sum = {1'b0, quo_r[ThrBits-1:0]} + (ThrBits+1)'(offs_r);
  assign thr = (|quo_r[NumBits-1:ThrBits] || thr_sum[ThrBits]) ? '1 : thr_sum[ThrBits-1:0];
  assign dtrial = {rem_r, num_r[NumBits-1]};
  assign mem_addr = (st_r == S_IDLE) ? ptr_r - PtrBits'(fill_r) :
                    (st_r == S_RDOLD) ? ptr_r - 1'b1 : ptr_r;
  assign mem_we = (st_r == S_DECIDE);
  assign sreq.start = (st_r == S_VAR);
  assign sreq.radicand = var_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_if.valid) st_nxt = (chk != StNone) ? S_OUT : S_RDOLD;
      S_RDOLD: st_nxt = S_VAR;
      S_VAR: st_nxt = (fill_r == '0) ? S_DECIDE : S_SQRT;
      S_SQRT: if (srsp.done) st_nxt = S_MUL;
      S_MUL: st_nxt = S_DIV;
      S_DIV: if (cnt_r == 6'd0) st_nxt = S_DECIDE;
      S_DECIDE: st_nxt = S_OUT;
      S_OUT: if (out_if.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic [FluxBits-1:0] old_r;
  logic plat, emit, cand;
  logic [2*FluxBits-1:0] old_sq, new_sq;
  assign plat = pval_r && pflx_r == flx_r;
  assign emit = pval_r && pflx_r > flx_r && (!emv_r || (pcen_r - lon_r) >= refr_r);
  assign cand = !plat && fill_r != '0 && flx_r > floor_r &&
                (ThrBits+1)'(flx_r) > (ThrBits+1)'(thr) && flx_r >= prev_r;
  assign old_sq = old_r * old_r;
  assign new_sq = flx_r * flx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      hist_r <= 7'd16; gain_r <= 12'd256; offs_r <= '0; floor_r <= '0; refr_r <= '0;
      pval_r <= 1'b0; emv_r <= 1'b0; seen_r <= 1'b0;
      ptr_r <= '0; fill_r <= '0; sum_r <= '0; sq_r <= '0;
      lfrm_r <= '0; lcen_r <= '0; lrdy_r <= '0; lon_r <= '0;
      pfrm_r <= '0; pcen_r <= '0; pflx_r <= '0; pthr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgHistory: begin
            hist_r <= cfg_data[6:0]; ptr_r <= '0; fill_r <= '0; sum_r <= '0; sq_r <= '0;
          end
          CfgGain: gain_r <= cfg_data[11:0];
          CfgOffset: offs_r <= cfg_data[FluxBits-1:0];
          CfgFloor: floor_r <= cfg_data[FluxBits-1:0];
          CfgRefract: refr_r <= cfg_data[TimeBits-1:0];
          default: ;
        endcase
      end
      if (st_r == S_DECIDE) begin
        ost_r <= emit ? StOnset : StNone;
        if (emit) begin
          ofrm_r <= pfrm_r; otime_r <= pcen_r; oemit_r <= rdy_r;
          odel_r <= rdy_r - pcen_r; oflx_r <= pflx_r; othr_r <= pthr_r;
          emv_r <= 1'b1; lon_r <= pcen_r;
        end
        pval_r <= plat || cand;
        if (plat || cand) begin
          pfrm_r <= frm_r; pcen_r <= cen_r;
        end
        if (cand) begin
          pflx_r <= flx_r; pthr_r <= thr;
        end
        ptr_r <= ptr_r + 1'b1;
        if (evict) begin
          sum_r <= sum_r - SumBits'(old_r) + SumBits'(flx_r);
          sq_r <= sq_r - SqBits'(old_sq) + SqBits'(new_sq);
        end else begin
          fill_r <= fill_r + 1'b1;
          sum_r <= sum_r + SumBits'(flx_r);
          sq_r <= sq_r + SqBits'(new_sq);
        end
        seen_r <= 1'b1; lfrm_r <= frm_r; lcen_r <= cen_r; lrdy_r <= rdy_r;
      end
    end
    if (st_r == S_IDLE && in_if.valid) begin
      frm_r <= in_frame; cen_r <= in_center; rdy_r <= in_ready;
      flx_r <= in_flux;
      ost_r <= chk; ofrm_r <= '0; otime_r <= '0; oemit_r <= '0; odel_r <= '0;
      oflx_r <= '0; othr_r <= '0;
    end
    if (st_r == S_RDOLD) begin
      old_r <= (fill_r == '0) ? '0 : mem_rd;
      var_r <= VarBits'(fill_r) * VarBits'(sq_r) - VarBits'(sum_r) * VarBits'(sum_r);
    end
    if (st_r == S_VAR) prev_r <= (fill_r == '0) ? '0 : mem_rd;
    if (st_r == S_MUL) begin
      num_r <= {sum_r, 8'd0} + NumBits'(gain_r) * NumBits'(srsp.root);
      rem_r <= '0; cnt_r <= 6'(NumBits); quo_r <= '0;
    end
    if (st_r == S_DIV && cnt_r != 6'd0) begin
      num_r <= {num_r[NumBits-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (dtrial >= (NumBits+1)'(den)) begin
        rem_r <= NumBits'(dtrial - (NumBits+1)'(den));
        quo_r <= {quo_r[NumBits-2:0], 1'b1};
      end else begin
        rem_r <= dtrial[NumBits-1:0];
        quo_r <= {quo_r[NumBits-2:0], 1'b0};
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !out_if.valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FillBits'(WindowDepth)) else $error("fill overflow");
`endif
endmodule

@@ hw/rtl/cop_ram.sv @@
// Generic single-port RAM with registered read.
module cop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/cop_sqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module cop_sqrt (
  input  logic clk,
  input  logic rst_n,
  input  cop_pkg::sqrt_req_t req,
  output cop_pkg::sqrt_rsp_t rsp
);
  import cop_pkg::*;
  localparam int CntBits = $clog2(RootBits + 1);
  logic [VarBits-1:0] rem_r, rem_nxt;
  logic [VarBits-1:0] v_r, v_nxt;
  logic [RootBits-1:0] q_r, q_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r;
  logic [VarBits-1:0] trial;

  always_comb begin
    rem_nxt = rem_r; v_nxt = v_r; q_nxt = q_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = '0;
    if (req.start) begin
      rem_nxt = '0; v_nxt = req.radicand; q_nxt = '0;
      cnt_nxt = CntBits'(RootBits); busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = {rem_r[VarBits-3:0], v_r[VarBits-1 -: 2]};
      v_nxt = {v_r[VarBits-3:0], 2'b00};
      trial = {{(VarBits-RootBits-2){1'b0}}, q_r, 2'b01};
      if (rem_nxt >= trial) begin
        rem_nxt = rem_nxt - trial;
        q_nxt = {q_r[RootBits-2:0], 1'b1};
      end else begin
        q_nxt = {q_r[RootBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
      done_r <= busy_r && cnt_r == CntBits'(1);
    end
    rem_r <= rem_nxt; v_r <= v_nxt; q_r <= q_nxt;
  end
  assign rsp = {done_r, q_r};
endmodule
